// ----- rtl/agts_pkg.sv -----
// Shared constants, register indexes and unit interface types of the temperature smoother.
package agts_pkg;

	localparam int TEMP_BITS  = 18;
	localparam int MAX_POWER  = 15;
	localparam int POW_W      = 4;
	localparam int GAIN_W     = 16;
	localparam int WID_W      = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;
	localparam int DIV_W      = WID_W;
	localparam int PROD_W     = GAIN_W + TEMP_BITS;
	localparam int CMP_W      = (TEMP_BITS > WID_W) ? TEMP_BITS : WID_W;
	localparam int CNT_W      = $clog2(MAX_POWER + 1);
	localparam int STUCK_DIFF = 100;

	localparam logic [POW_W-1:0]  RST_GAIN_POWER = POW_W'(7);
	localparam logic [GAIN_W-1:0] RST_GAIN_MIN   = GAIN_W'(10);
	localparam logic [GAIN_W-1:0] RST_GAIN_MAX   = GAIN_W'(1000);
	localparam logic [GAIN_W-1:0] RST_GAIN_SCALE = GAIN_W'(1000);
	localparam logic [WID_W-1:0]  RST_RISE_WIDTH = WID_W'(5000);
	localparam logic [WID_W-1:0]  RST_FALL_WIDTH = WID_W'(15000);

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_POWER = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_MIN   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_MAX   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_SCALE = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_RISE_WIDTH = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_FALL_WIDTH = CFG_IDX_W'(5);

	// Request to the shared multiply-divide unit: quotient = a * b / d.
	typedef struct packed {
		logic              start;
		logic [GAIN_W-1:0] a;
		logic [TEMP_BITS-1:0] b;
		logic [DIV_W-1:0]  d;
	} md_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [PROD_W-1:0] quo;
	} md_rsp_t;

endpackage

// ----- rtl/agts_muldiv.sv -----
// Shared multiply then restoring divide unit, one quotient bit per cycle.
module agts_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  agts_pkg::md_req_t req,
	output agts_pkg::md_rsp_t rsp
);
	import agts_pkg::*;

	localparam int ITER_W = $clog2(PROD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic [PROD_W-1:0] quo_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  div_q;
	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    trial_sub;
	logic              fits;

	// The partial remainder always stays below the divisor, so it fits in DIV_W bits.
	always_comb begin
		trial     = {rem_q, quo_q[PROD_W-1]};
		fits      = (trial >= {1'b0, div_q});
		trial_sub = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(PROD_W);
			end else if (busy_q) begin
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= PROD_W'(req.a) * PROD_W'(req.b);
			rem_q <= '0;
			div_q <= req.d;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ----- rtl/adaptive_gain_temperature_smoother.sv -----
// Top level of the adaptive-gain temperature smoother: sequencer, registers and result stage.
// The block keeps a running average of temperature samples (millidegrees), zero after reset,
// and moves it toward each new sample by a gain that grows with the distance between the two:
// gain = gain_min + (gain_max - gain_min) * (diff / width)^power, evaluated one factor at a
// time with truncating division, and new average = old + gain * (sample - old) / gain_scale,
// truncated toward zero and saturated to the signed sample range. All multiply and divide work
// runs through one shared unit that forms a product and then divides it restoring-style, one
// quotient bit per cycle; each pass yields 34 quotient bits, and both the request to the unit
// and its done strobe are registered. A sample makes p + 1 passes through the unit, where p is
// the effective power (0 counts as 1, capped at 15); when the gain clamps early (difference at
// least the width, or gain_max not above gain_min) only the final pass runs. A result still
// waiting in the output register holds the sequencer in its last state until it is taken.
// in_ready is high only while no sample is in work. The finished result sits in an output
// register until it is taken, and the running average is updated when that register is
// loaded. The stuck flag reports a difference of at least 100 that left the average unchanged.
// Configuration registers are written through cfg_we, cfg_index and cfg_data; writes to an
// index beyond the last register are ignored, and a zero width or a zero scale acts as one.
module adaptive_gain_temperature_smoother (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [agts_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [agts_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [agts_pkg::TEMP_BITS-1:0] raw_temp,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [agts_pkg::TEMP_BITS-1:0] new_average,
	output logic [agts_pkg::GAIN_W-1:0]          gain_used,
	output logic                                 rising,
	output logic                                 stuck
);
	import agts_pkg::*;

	localparam int SUM_W = PROD_W + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_POW_WAIT,
		ST_SCALE_WAIT,
		ST_FINISH
	} state_t;

	// Configuration registers.
	logic [POW_W-1:0]  gain_power_q;
	logic [GAIN_W-1:0] gain_min_q;
	logic [GAIN_W-1:0] gain_max_q;
	logic [GAIN_W-1:0] gain_scale_q;
	logic [WID_W-1:0]  rise_width_q;
	logic [WID_W-1:0]  fall_width_q;

	// Sequencer state and per-sample working registers.
	state_t                 state_q;
	logic signed [TEMP_BITS-1:0] avg_q;
	logic [TEMP_BITS-1:0]   diff_q;
	logic                   neg_q;
	logic                   rising_q;
	logic [WID_W-1:0]       width_q;
	logic [CNT_W-1:0]       pcnt_q;
	logic [GAIN_W-1:0]      gain_q;
	logic signed [TEMP_BITS-1:0] next_q;
	logic                   stuck_q;
	md_req_t                md_req_q;
	md_rsp_t                md_rsp;

	// Output register.
	logic                   out_valid_q;
	logic signed [TEMP_BITS-1:0] out_avg_q;
	logic [GAIN_W-1:0]      out_gain_q;
	logic                   out_rising_q;
	logic                   out_stuck_q;

	// Combinational helpers.
	logic signed [TEMP_BITS:0] delta;
	logic [TEMP_BITS:0]     delta_mag;
	logic                   delta_pos;
	logic [WID_W-1:0]       width_sel;
	logic [WID_W-1:0]       width_eff;
	logic [GAIN_W-1:0]      scale_eff;
	logic [DIV_W-1:0]       scale_div;
	logic [7:0]             pow_wide;
	logic [CNT_W-1:0]       pow_eff;
	logic                   early_clamp;
	logic [GAIN_W-1:0]      span;
	logic [GAIN_W-1:0]      multi;
	logic [GAIN_W:0]        gain_sum;
	logic [GAIN_W-1:0]      gain_next;
	logic signed [SUM_W-1:0] old_x;
	logic signed [SUM_W-1:0] step_x;
	logic signed [SUM_W-1:0] sum_x;
	logic signed [SUM_W-1:0] hi_x;
	logic signed [SUM_W-1:0] lo_x;
	logic signed [TEMP_BITS-1:0] next_sat;
	logic                   stuck_next;

	agts_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req_q),
		.rsp    (md_rsp)
	);

	always_comb begin
		// Difference between the incoming sample and the running average.
		delta     = {raw_temp[TEMP_BITS-1], raw_temp} - {avg_q[TEMP_BITS-1], avg_q};
		delta_mag = delta[TEMP_BITS] ? (~delta + 1'b1) : delta;
		delta_pos = !delta[TEMP_BITS] && (delta != '0);
		width_sel = delta_pos ? rise_width_q : fall_width_q;
		width_eff = (width_sel == '0) ? WID_W'(1) : width_sel;

		scale_eff = (gain_scale_q == '0) ? GAIN_W'(1) : gain_scale_q;
		scale_div = DIV_W'(scale_eff);

		// Power of zero acts as one, and the power never exceeds the supported cap.
		pow_wide = 8'(gain_power_q);
		if (pow_wide == 8'd0) begin
			pow_wide = 8'd1;
		end
		if (pow_wide > 8'(MAX_POWER)) begin
			pow_wide = 8'(MAX_POWER);
		end
		pow_eff = CNT_W'(pow_wide);

		early_clamp = (gain_max_q <= gain_min_q) || (CMP_W'(diff_q) >= CMP_W'(width_q));
		span        = gain_max_q - gain_min_q;

		// Each factor is below one, so the running product never exceeds the span.
		multi     = md_rsp.quo[GAIN_W-1:0];
		gain_sum  = {1'b0, gain_min_q} + {1'b0, multi};
		gain_next = (gain_sum > {1'b0, gain_max_q}) ? gain_max_q : gain_sum[GAIN_W-1:0];

		// Apply the step with the sign of the difference, then saturate.
		old_x  = {{(SUM_W-TEMP_BITS){avg_q[TEMP_BITS-1]}}, avg_q};
		step_x = {2'b00, md_rsp.quo};
		sum_x  = neg_q ? (old_x - step_x) : (old_x + step_x);
		hi_x   = {{(SUM_W-TEMP_BITS+1){1'b0}}, {(TEMP_BITS-1){1'b1}}};
		lo_x   = ~hi_x;
		if (sum_x > hi_x) begin
			next_sat = hi_x[TEMP_BITS-1:0];
		end else if (sum_x < lo_x) begin
			next_sat = lo_x[TEMP_BITS-1:0];
		end else begin
			next_sat = sum_x[TEMP_BITS-1:0];
		end
		stuck_next = (CMP_W'(diff_q) >= CMP_W'(STUCK_DIFF)) && (next_sat == avg_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_power_q <= RST_GAIN_POWER;
			gain_min_q   <= RST_GAIN_MIN;
			gain_max_q   <= RST_GAIN_MAX;
			gain_scale_q <= RST_GAIN_SCALE;
			rise_width_q <= RST_RISE_WIDTH;
			fall_width_q <= RST_FALL_WIDTH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_POWER: gain_power_q <= cfg_data[POW_W-1:0];
				REG_GAIN_MIN:   gain_min_q   <= cfg_data[GAIN_W-1:0];
				REG_GAIN_MAX:   gain_max_q   <= cfg_data[GAIN_W-1:0];
				REG_GAIN_SCALE: gain_scale_q <= cfg_data[GAIN_W-1:0];
				REG_RISE_WIDTH: rise_width_q <= cfg_data[WID_W-1:0];
				REG_FALL_WIDTH: fall_width_q <= cfg_data[WID_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: one clocked block holds the state, the unit requests and the result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			avg_q        <= '0;
			diff_q       <= '0;
			neg_q        <= 1'b0;
			rising_q     <= 1'b0;
			width_q      <= '0;
			pcnt_q       <= '0;
			gain_q       <= '0;
			next_q       <= '0;
			stuck_q      <= 1'b0;
			md_req_q     <= '0;
			out_valid_q  <= 1'b0;
			out_avg_q    <= '0;
			out_gain_q   <= '0;
			out_rising_q <= 1'b0;
			out_stuck_q  <= 1'b0;
		end else begin
			md_req_q.start <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						diff_q   <= delta_mag[TEMP_BITS-1:0];
						neg_q    <= delta[TEMP_BITS];
						rising_q <= delta_pos;
						width_q  <= width_eff;
						state_q  <= ST_PREP;
					end
				end
				ST_PREP: begin
					md_req_q.start <= 1'b1;
					md_req_q.b     <= diff_q;
					if (early_clamp) begin
						gain_q     <= gain_max_q;
						md_req_q.a <= gain_max_q;
						md_req_q.d <= scale_div;
						state_q    <= ST_SCALE_WAIT;
					end else begin
						pcnt_q     <= pow_eff;
						md_req_q.a <= span;
						md_req_q.d <= DIV_W'(width_q);
						state_q    <= ST_POW_WAIT;
					end
				end
				ST_POW_WAIT: begin
					if (md_rsp.done) begin
						md_req_q.start <= 1'b1;
						if (pcnt_q == CNT_W'(1)) begin
							gain_q     <= gain_next;
							md_req_q.a <= gain_next;
							md_req_q.d <= scale_div;
							state_q    <= ST_SCALE_WAIT;
						end else begin
							pcnt_q     <= pcnt_q - CNT_W'(1);
							md_req_q.a <= multi;
							state_q    <= ST_POW_WAIT;
						end
					end
				end
				ST_SCALE_WAIT: begin
					if (md_rsp.done) begin
						next_q  <= next_sat;
						stuck_q <= stuck_next;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// Hold the result until the output register is free.
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_avg_q    <= next_q;
						out_gain_q   <= gain_q;
						out_rising_q <= rising_q;
						out_stuck_q  <= stuck_q;
						avg_q        <= next_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign new_average = out_avg_q;
	assign gain_used   = out_gain_q;
	assign rising      = out_rising_q;
	assign stuck       = out_stuck_q;

`ifndef ASSERT_OFF
	// A new sample is only taken while the shared unit is quiet.
	a_ready_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !md_rsp.busy)
		else $error("sample accepted while the multiply-divide unit is busy");

	// The unit only reports completion while the sequencer waits for it.
	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> (state_q == ST_POW_WAIT || state_q == ST_SCALE_WAIT))
		else $error("unexpected completion from the multiply-divide unit");

	// The applied gain never exceeds the configured maximum.
	a_gain_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_gain_q <= gain_max_q))
		else $error("gain above gain_max");

	// A stuck result means the running average kept its value.
	a_stuck_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stuck_q) |-> (out_avg_q == avg_q))
		else $error("stuck flag set but average moved");
`endif

endmodule
